/* src/mm64a_pkg.sv */
// Shared types and constants for the MurmurHash64A block.
// No dependencies; used by mm64a_mul and murmur64a_hash_top.
`default_nettype none

package mm64a_pkg;

    localparam logic [63:0] MixMul   = 64'hc6a4a7935bd1e995;
    localparam int unsigned MixShift = 47;

    localparam int unsigned WordBytes = 8;
    localparam int unsigned CountW    = 4;
    localparam int unsigned LenW      = 32;
    localparam int unsigned AddrW     = 3;

    localparam logic [AddrW-1:0] RegHashSeed = 3'd0;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SEED     = 8'b0000_0010,
        S_DISPATCH = 8'b0000_0100,
        S_K1       = 8'b0000_1000,
        S_K2       = 8'b0001_0000,
        S_HMUL     = 8'b0010_0000,
        S_END      = 8'b0100_0000,
        S_FIN      = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] operand;
    } mul_req_t;

    typedef struct packed {
        logic        busy;
        logic [63:0] product;
    } mul_rsp_t;

    function automatic logic [63:0] xorshift(input logic [63:0] v);
        xorshift = v ^ (v >> MixShift);
    endfunction

endpackage

`default_nettype wire

/* src/mm64a_mul.sv */
// Multiplies a 64-bit operand by the mixing constant, modulo 2**64, on one
// 32x32 multiplier, taking low by low, low by high, then high by low. Depends on mm64a_pkg.
`default_nettype none

module mm64a_mul
    import mm64a_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire mul_req_t req,
    output mul_rsp_t      rsp
);

    logic [63:0] op_reg, op_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic [31:0] mul_x, mul_y;
    logic [63:0] prod;

    always_comb begin
        case (step_reg)
            2'd0: begin
                mul_x = op_reg[31:0];
                mul_y = MixMul[31:0];
            end
            2'd1: begin
                mul_x = op_reg[31:0];
                mul_y = MixMul[63:32];
            end
            default: begin
                mul_x = op_reg[63:32];
                mul_y = MixMul[31:0];
            end
        endcase
    end

    assign prod = 64'(mul_x) * 64'(mul_y);

    always_comb begin
        op_next   = op_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (req.start) begin
            op_next   = req.operand;
            step_next = 2'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (step_reg == 2'd0) begin
                acc_next = prod;
            end else begin
                acc_next[63:32] = acc_reg[63:32] + prod[31:0];
            end
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd2) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
        op_reg  <= op_next;
        acc_reg <= acc_next;
    end

    assign rsp.busy    = busy_reg;
    assign rsp.product = acc_reg;

endmodule

`default_nettype wire

/* src/murmur64a_hash_top.sv */
// Top level of the streaming MurmurHash64A block with its register port.
// Depends on mm64a_pkg and mm64a_mul.
// One item is taken at a time. Every multiplication by the mixing constant
// holds the shared 32x32 multiplier until it is done, and the state machine
// then hands its product on. A full word needs three such products, a short
// word one and an empty word none. A first word adds the length product and a
// last word adds one more to finalise, and the result may further wait while
// the previous result still waits on the receiver.
`default_nettype none

module murmur64a_hash_top
    import mm64a_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // data_word[63:0], valid_bytes[67:64], message_length[99:68], zero fill
    input  wire logic [103:0]     s_tdata,
    // first_item
    input  wire logic             s_tuser,
    input  wire logic             s_tlast,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // hash_value[63:0]
    output logic [63:0]           m_tdata,
    // framing_error
    output logic                  m_tuser,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [AddrW-1:0] paddr,
    input  wire logic [63:0]      pwdata,
    output logic [63:0]           prdata,
    output logic                  pready
);

    state_t state_reg, state_next;
    logic [63:0]       seed_reg, hash_reg, hash_next, word_reg, word_next;
    logic [CountW-1:0] nb_reg, nb_in;
    logic              last_reg, err_reg, err_next;
    logic [63:0]       out_data_reg, out_data_next;
    logic              out_err_reg, out_err_next;
    logic              out_valid_reg, out_valid_next;
    logic              in_fire, cfg_write;
    logic [CountW-1:0] valid_in;
    mul_req_t          mreq;
    mul_rsp_t          mrsp;

    assign pready    = 1'b1;
    assign prdata    = (paddr == RegHashSeed) ? seed_reg : '0;
    assign cfg_write = psel && penable && pwrite && pready;

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign valid_in = s_tdata[67:64];
    assign nb_in    = (valid_in > CountW'(WordBytes)) ? CountW'(WordBytes) : valid_in;

    always_comb begin
        for (int unsigned i = 0; i < WordBytes; i++) begin
            word_next[i*8 +: 8] = (CountW'(i) < nb_in) ? s_tdata[i*8 +: 8] : 8'h00;
        end
    end

    mm64a_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    always_comb begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        err_next       = err_reg;
        out_data_next  = out_data_reg;
        out_err_next   = out_err_reg;
        out_valid_next = out_valid_reg && !m_tready;
        mreq.start     = 1'b0;
        mreq.operand   = hash_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    if (s_tuser) begin
                        mreq.start   = 1'b1;
                        mreq.operand = 64'(s_tdata[99:68]);
                        state_next   = S_SEED;
                    end else begin
                        state_next = S_DISPATCH;
                    end
                end
            end
            S_SEED: begin
                if (!mrsp.busy) begin
                    hash_next  = seed_reg ^ mrsp.product;
                    err_next   = 1'b0;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (nb_reg == CountW'(WordBytes)) begin
                    mreq.start   = 1'b1;
                    mreq.operand = word_reg;
                    state_next   = S_K1;
                end else if (nb_reg != '0) begin
                    mreq.start   = 1'b1;
                    mreq.operand = hash_reg ^ word_reg;
                    state_next   = S_HMUL;
                end else begin
                    state_next = S_END;
                end
            end
            S_K1: begin
                if (!mrsp.busy) begin
                    mreq.start   = 1'b1;
                    mreq.operand = xorshift(mrsp.product);
                    state_next   = S_K2;
                end
            end
            S_K2: begin
                if (!mrsp.busy) begin
                    mreq.start   = 1'b1;
                    mreq.operand = hash_reg ^ mrsp.product;
                    state_next   = S_HMUL;
                end
            end
            S_HMUL: begin
                if (!mrsp.busy) begin
                    hash_next  = mrsp.product;
                    state_next = S_END;
                end
            end
            S_END: begin
                if (!last_reg) begin
                    if (nb_reg != CountW'(WordBytes)) begin
                        err_next = 1'b1;
                    end
                    state_next = S_IDLE;
                end else begin
                    mreq.start   = 1'b1;
                    mreq.operand = xorshift(hash_reg);
                    state_next   = S_FIN;
                end
            end
            S_FIN: begin
                if (!mrsp.busy && (!out_valid_reg || m_tready)) begin
                    out_data_next  = xorshift(mrsp.product);
                    out_err_next   = err_reg;
                    out_valid_next = 1'b1;
                    err_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            seed_reg      <= '0;
            hash_reg      <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write) begin
                seed_reg <= pwdata;
            end
        end
        if (in_fire) begin
            word_reg <= word_next;
            nb_reg   <= nb_in;
            last_reg <= s_tlast;
        end
        out_data_reg <= out_data_next;
        out_err_reg  <= out_err_next;
    end

    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;
    assign m_tvalid = out_valid_reg;

    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        mreq.start |-> !mrsp.busy)
        else $error("multiplier started while busy");

    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result appeared outside finalisation");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> state_reg != S_IDLE)
        else $error("accepted transaction did not start work");

    a_fin_needs_last: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FIN |-> last_reg)
        else $error("finalisation without a last word");

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for murmur64a_hash_top: message words go in on the slave stream and
// every digest on the master stream is checked against an in-line MurmurHash64A predictor.
// Depends on mm64a_pkg and the RTL of murmur64a_hash_top.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mm64a_pkg::*;

    localparam logic [63:0] MUR_M         = 64'hc6a4a7935bd1e995;
    localparam int          MUR_R         = 47;
    localparam int          SETTLE_CYCLES = 48;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          PHASE_ITEMS   = 410;
    localparam int          HOLD_ITEMS    = 30;
    localparam int unsigned CYCLE_LIMIT   = 600000;

    typedef struct {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        first;
        logic        last;
        logic [31:0] length;
    } msg_word_t;

    typedef struct {
        logic [63:0] hash;
        logic        err;
    } digest_t;

    typedef struct {
        msg_word_t   w;
        bit          hash_typed;
        logic [63:0] hash_val;
        bit          err_typed;
        logic        err_val;
    } vec_t;

    logic             aclk;
    logic             aresetn;
    logic [103:0]     s_tdata;
    logic             s_tuser;
    logic             s_tlast;
    logic             s_tvalid;
    logic             s_tready;
    logic [63:0]      m_tdata;
    logic             m_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [63:0]      pwdata;
    logic [63:0]      prdata;
    logic             pready;

    logic [63:0] seed_shadow;
    logic [63:0] hash_acc;
    logic        err_pending;
    digest_t     digest_q[$];
    msg_word_t   plan_q[$];
    vec_t        vec_q[$];
    digest_t     got_d;
    int          fail_cnt;
    int          src_idle_pct;
    int          sink_stall_pct;
    int          hold_left;
    int unsigned cycle_cnt;

    murmur64a_hash_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic void flag_mismatch(input string what);
        fail_cnt++;
        if (fail_cnt <= 10) $display("mismatch: %s", what);
    endfunction

    // Absorbs one accepted word into the running hash; returns 1 when a digest is due.
    function automatic bit murmur_absorb(input msg_word_t w, output digest_t d);
        logic [63:0] k;
        logic [63:0] h;
        int          n;
        n = (w.nbytes > 4'd8) ? 8 : int'(w.nbytes);
        if (w.first) begin
            hash_acc    = seed_shadow ^ ({32'd0, w.length} * MUR_M);
            err_pending = 1'b0;
        end
        if (n == 8) begin
            k        = w.word * MUR_M;
            k        = k ^ (k >> MUR_R);
            k        = k * MUR_M;
            hash_acc = (hash_acc ^ k) * MUR_M;
        end else if (n > 0) begin
            k        = w.word & ((64'd1 << (8 * n)) - 64'd1);
            hash_acc = (hash_acc ^ k) * MUR_M;
        end
        d.hash = '0;
        d.err  = 1'b0;
        if (!w.last) begin
            if (n < 8) err_pending = 1'b1;
            return 1'b0;
        end
        h           = hash_acc ^ (hash_acc >> MUR_R);
        h           = h * MUR_M;
        d.hash      = h ^ (h >> MUR_R);
        d.err       = err_pending;
        err_pending = 1'b0;
        return 1'b1;
    endfunction

    function automatic void add_vec(input logic [63:0] word, input logic [3:0] nb,
                                    input logic f, input logic l, input logic [31:0] len,
                                    input bit ht = 1'b0, input logic [63:0] hv = '0,
                                    input bit et = 1'b0, input logic ev = 1'b0);
        vec_t v;
        v.w.word     = word;
        v.w.nbytes   = nb;
        v.w.first    = f;
        v.w.last     = l;
        v.w.length   = len;
        v.hash_typed = ht;
        v.hash_val   = hv;
        v.err_typed  = et;
        v.err_val    = ev;
        vec_q.push_back(v);
    endfunction

    // Queues the words of one random message: mostly well formed, some noise and broken framing.
    function automatic void plan_message();
        msg_word_t w;
        int        len;
        int        nw;
        int        kind;
        int        brk;
        kind = $urandom_range(99);
        if (kind < 6) begin
            w.word   = {$urandom, $urandom};
            w.nbytes = 4'($urandom_range(15));
            w.first  = 1'($urandom_range(1));
            w.last   = 1'($urandom_range(1));
            w.length = $urandom;
            plan_q.push_back(w);
            return;
        end
        len = (kind < 11) ? $urandom_range(400, 41) : $urandom_range(40, 0);
        nw  = (len == 0) ? 1 : (len + 7) / 8;
        brk = (kind >= 88 && nw > 1) ? $urandom_range(nw - 2, 0) : -1;
        for (int i = 0; i < nw; i++) begin
            w.word  = {$urandom, $urandom};
            w.first = (i == 0) && (kind < 95);
            w.last  = (i == nw - 1);
            if (len == 0) begin
                w.nbytes = 4'd0;
            end else if (w.last && (len % 8) != 0) begin
                w.nbytes = 4'(len % 8);
            end else begin
                w.nbytes = 4'd8;
            end
            if (w.nbytes == 4'd8 && $urandom_range(19) == 0) w.nbytes = 4'($urandom_range(15, 9));
            if (i == brk) w.nbytes = 4'($urandom_range(7, 0));
            w.length = (i == 0 && $urandom_range(9) != 0) ? 32'(len) : $urandom;
            plan_q.push_back(w);
        end
    endfunction

    // Entered and left just after a falling edge; valid stays high if the next call follows with no idle turns.
    task automatic send_item(input vec_t v);
        digest_t d;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= {4'd0, v.w.length, v.w.nbytes, v.w.word};
        s_tuser  <= v.w.first;
        s_tlast  <= v.w.last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (murmur_absorb(v.w, d)) begin
            if (v.hash_typed) d.hash = v.hash_val;
            if (v.err_typed) d.err = v.err_val;
            digest_q.push_back(d);
        end
        @(negedge aclk);
    endtask

    task automatic send_planned(input int count);
        vec_t v;
        for (int n = 0; n < count; n++) begin
            if (plan_q.size() == 0) plan_message();
            v.w          = plan_q.pop_front();
            v.hash_typed = 1'b0;
            v.hash_val   = '0;
            v.err_typed  = 1'b0;
            v.err_val    = 1'b0;
            send_item(v);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (digest_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_seed(input logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RegHashSeed;
        pwdata  <= v;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        seed_shadow = v;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== v) flag_mismatch($sformatf("seed readback exp %h got %h", v, prdata));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (digest_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected digest %h err %b", m_tdata, m_tuser));
            end else begin
                got_d = digest_q.pop_front();
                if (m_tdata !== got_d.hash)
                    flag_mismatch($sformatf("hash exp %h got %h", got_d.hash, m_tdata));
                if (m_tuser !== got_d.err)
                    flag_mismatch($sformatf("framing error exp %b got %b", got_d.err, m_tuser));
            end
        end
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        aresetn        = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        s_tlast        = 1'b0;
        s_tvalid       = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        seed_shadow    = '0;
        hash_acc       = '0;
        err_pending    = 1'b0;
        fail_cnt       = 0;
        src_idle_pct   = 22;
        sink_stall_pct = 22;
        hold_left      = 0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Seed is zero after reset, so an empty zero-length message hashes to zero.
        add_vec(64'h0123456789abcdef, 4'd0, 1'b1, 1'b1, 32'd0, 1'b1, 64'd0, 1'b1, 1'b0);
        add_vec('1, 4'd8, 1'b1, 1'b1, 32'd8, 1'b0, '0, 1'b1, 1'b0);
        add_vec('0, 4'd8, 1'b1, 1'b1, 32'd8);
        add_vec('1, 4'd1, 1'b1, 1'b1, 32'd1);
        add_vec('1, 4'd7, 1'b1, 1'b1, 32'd7);
        add_vec(64'hfedcba9876543210, 4'd15, 1'b1, 1'b1, 32'd8);
        add_vec(64'hfedcba9876543210, 4'd9, 1'b1, 1'b1, 32'd8);
        add_vec(64'h8000000000000001, 4'd8, 1'b1, 1'b0, 32'd19);
        add_vec(64'h5555aaaa5555aaaa, 4'd8, 1'b0, 1'b0, '1);
        add_vec('1, 4'd3, 1'b0, 1'b1, 32'd0, 1'b0, '0, 1'b1, 1'b0);
        add_vec('1, 4'd5, 1'b1, 1'b0, 32'd13);
        add_vec('1, 4'd8, 1'b0, 1'b1, 32'd0, 1'b0, '0, 1'b1, 1'b1);
        add_vec(64'h1122334455667788, 4'd0, 1'b1, 1'b0, 32'd0);
        add_vec(64'h1122334455667788, 4'd0, 1'b0, 1'b1, 32'd0, 1'b0, '0, 1'b1, 1'b1);
        add_vec('1, 4'd8, 1'b0, 1'b1, '1, 1'b0, '0, 1'b1, 1'b0);
        add_vec('1, 4'd8, 1'b1, 1'b1, '1);
        add_vec(64'h0f0f0f0f0f0f0f0f, 4'd8, 1'b1, 1'b0, 32'd100);
        add_vec(64'hf0f0f0f0f0f0f0f0, 4'd8, 1'b0, 1'b1, 32'd0);
        add_vec(64'h00000000deadbeef, 4'd3, 1'b1, 1'b0, 32'd3);
        add_vec(64'hcafef00dcafef00d, 4'd8, 1'b1, 1'b1, 32'd8, 1'b0, '0, 1'b1, 1'b0);
        add_vec(64'h0000000000000000, 4'd0, 1'b0, 1'b1, 32'd0, 1'b0, '0, 1'b1, 1'b0);
        foreach (vec_q[i]) send_item(vec_q[i]);

        for (int p = 0; p < 4; p++) begin
            settle();
            case (p)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                    set_seed('1);
                end
                1: begin
                    src_idle_pct   = 66;
                    sink_stall_pct = 0;
                    set_seed({$urandom, $urandom});
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 66;
                    set_seed('0);
                end
                default: begin
                    src_idle_pct   = 22;
                    sink_stall_pct = 22;
                    set_seed({1'b1, 31'($urandom), $urandom});
                end
            endcase
            send_planned(PHASE_ITEMS);
        end

        // The receiver holds off while words keep coming, so the block backs up to its input.
        settle();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        set_seed({$urandom, $urandom});
        hold_left = HOLD_CYCLES;
        send_planned(HOLD_ITEMS);
        settle();

        if (fail_cnt == 0 && digest_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
